// ===== hdl/dedup_circular_fifo_core_assert.svh =====
// Assertion macros for the deduplicating FIFO core.
// Used by the top level only; no other dependencies.
`ifndef DEDUP_CIRCULAR_FIFO_CORE_ASSERT_SVH
`define DEDUP_CIRCULAR_FIFO_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DCF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcf assertion failed");

// Next-cycle implication, disabled during reset
`define DCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcf assertion failed");

`endif

// ===== hdl/dcf_pkg.sv =====
// Shared constants and types for the deduplicating FIFO core.
// No dependencies; imported by dcf_cell and dedup_circular_fifo_core.
package dcf_pkg;

   // Queue geometry
   localparam int DEPTH       = 16;
   localparam int KEY_WIDTH   = 32;
   // The key field is 32 bits wide, so no more than 32 bits are ever kept
   localparam int KEY_BITS    = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // Field widths on the ports
   localparam int KEY_FIELD_WIDTH = 32;
   localparam int OCC_WIDTH       = 5;
   localparam int STATUS_WIDTH    = 3;

   typedef logic [KEY_BITS-1:0]     key_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;

   // Operation codes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Result status codes
   localparam status_type ST_ENQUEUED  = 3'd0;
   localparam status_type ST_DUPLICATE = 3'd1;
   localparam status_type ST_FULL      = 3'd2;
   localparam status_type ST_DEQUEUED  = 3'd3;
   localparam status_type ST_EMPTY     = 3'd4;

   // Per-cell control from the queue controller
   typedef struct packed {
      logic occupied;  // cell lies below the fill count
      logic load;      // capture the incoming key
      logic shift;     // take the key of the next cell up
   } cell_ctrl_type;

endpackage

// ===== hdl/dedup_circular_fifo_core.sv =====
// Top level of the deduplicating FIFO: queue controller, cell chain, output register.
// Depends on dcf_pkg, dcf_cell and dedup_circular_fifo_core_assert.svh.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------------
//   req_     | in  | req_tvalid/tready  | tuser: operation; tdata: item_key
//   rsp_     | out | rsp_tvalid/tready  | tuser: status; tdata: out_key, occupancy
//
// One word is accepted per cycle; its result appears in the output register on the
// next cycle. The membership check compares the probe against every occupied cell in the same
// cycle, and cells shift toward cell 0 on a dequeue, so cell 0 always holds the oldest key.
// A new word is taken while the output register is empty or being drained.
// Reset (synchronous, active high) clears the fill count and the output valid;
// cell contents are not reset.
module dedup_circular_fifo_core
   import dcf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] operation
   input  logic [31:0] req_tdata,   // [31:0] item_key
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic [39:0] rsp_tdata    // [31:0] out_key, [36:32] occupancy, [39:37] zero
);

`include "dedup_circular_fifo_core_assert.svh"

   count_type  count_ff;
   count_type  count_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   status_type rsp_status_ff;
   status_type rsp_status_in;
   key_type    rsp_key_ff;
   key_type    rsp_key_in;
   count_type  rsp_occ_ff;

   logic          accept;
   logic          is_enqueue;
   logic          hit;
   logic          full;
   logic          empty;
   logic          insert_ok;
   logic          remove_ok;
   key_type       probe_key;
   key_type       cell_key [DEPTH];
   key_type       cell_next [DEPTH];
   logic [DEPTH-1:0] cell_match;
   cell_ctrl_type cell_ctrl [DEPTH];

   // Handshake and decode
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_enqueue = (req_tuser[0] == OP_ENQUEUE);
   assign probe_key  = KEY_BITS'(req_tdata);
   assign hit        = |cell_match;
   assign full       = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty      = (count_ff == '0);
   assign insert_ok  = accept && is_enqueue && !hit && !full;
   assign remove_ok  = accept && !is_enqueue && !empty;

   // Cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_end
         assign cell_next[i] = '0;
      end else begin : g_mid
         assign cell_next[i] = cell_key[i+1];
      end

      assign cell_ctrl[i].occupied = (COUNT_WIDTH'(i) < count_ff);
      assign cell_ctrl[i].load     = insert_ok && (count_ff == COUNT_WIDTH'(i));
      assign cell_ctrl[i].shift    = remove_ok;

      dcf_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[i]),
         .probe_key (probe_key),
         .next_key  (cell_next[i]),
         .key_out   (cell_key[i]),
         .match     (cell_match[i])
      );
   end

   // Status and next fill count
   always_comb begin
      rsp_status_in = ST_ENQUEUED;
      rsp_key_in    = '0;
      count_in      = count_ff;
      if (is_enqueue) begin
         if (hit) begin
            rsp_status_in = ST_DUPLICATE;
         end else if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in = ST_ENQUEUED;
            count_in      = count_ff + 1'b1;
         end
      end else begin
         if (empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_status_in = ST_DEQUEUED;
            rsp_key_in    = cell_key[0];
            count_in      = count_ff - 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_occ_ff    <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, OCC_WIDTH'(rsp_occ_ff), KEY_FIELD_WIDTH'(rsp_key_ff)};

   // Assertions
   `DCF_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, count_ff <= COUNT_WIDTH'(DEPTH))
   `DCF_ASSERT_NEXT(a_insert_grows, clock, reset, insert_ok, count_ff == $past(count_ff) + 1'b1)
   `DCF_ASSERT_NEXT(a_remove_status, clock, reset, remove_ok, rsp_status_ff == ST_DEQUEUED)
   `DCF_ASSERT_IMPLY(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready)

endmodule

// ===== hdl/dcf_cell.sv =====
// One storage cell of the key chain: holds a key, compares it against the probe.
// Depends on dcf_pkg.
module dcf_cell
   import dcf_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  key_type       probe_key,
   input  key_type       next_key,
   output key_type       key_out,
   output logic          match
);

   key_type key_ff;
   key_type key_in;

   // Load wins over shift; the controller never asserts both
   always_comb begin
      if (ctrl.load) begin
         key_in = probe_key;
      end else if (ctrl.shift) begin
         key_in = next_key;
      end else begin
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out = key_ff;
   // Only occupied cells take part in the membership check
   assign match   = ctrl.occupied && (key_ff == probe_key);

endmodule
